[hw/rtl/nsr_pkg.sv]
`timescale 1ns / 1ps

package nsr_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int IN_W          = 32;
    localparam int ROOT_W        = 24;
    // Widened radicand: the magnitude bits of a non-negative input, shifted left.
    localparam int VAL_W         = IN_W - 1 + FRACTION_BITS;
    localparam int CNT_W         = $clog2(VAL_W + 1);

    typedef struct packed {
        logic start;
    } nsr_div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } nsr_div_stat_t;

endpackage

[hw/rtl/nsr_divider.sv]
`timescale 1ns / 1ps

module nsr_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  nsr_pkg::nsr_div_ctrl_t        ctrl,
    input  logic [nsr_pkg::VAL_W-1:0]     dividend,
    input  logic [nsr_pkg::VAL_W-1:0]     divisor,
    output nsr_pkg::nsr_div_stat_t        stat,
    output logic [nsr_pkg::VAL_W-1:0]     quotient
);
    import nsr_pkg::*;

    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [VAL_W-1:0] dq_reg, dq_next;
    logic [VAL_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [VAL_W:0]   trial;
    logic             fits;

    // One quotient bit per cycle: the dividend shifts out of the top of dq_reg
    // into the partial remainder while quotient bits shift in at the bottom.
    assign trial = {rem_reg, dq_reg[VAL_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            rem_next  = '0;
            dq_next   = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(VAL_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = VAL_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[VAL_W-1:0];
            end
            dq_next  = {dq_reg[VAL_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dsr_reg <= dsr_next;
    end

    assign stat     = {busy_reg, done_reg};
    assign quotient = dq_reg;

endmodule

[hw/rtl/newton_square_root.sv]
`timescale 1ns / 1ps

// Channel  Direction  Payload
// s_       in         s_tdata[31:0] = radicand (signed Q16.16)
// m_       out        m_tdata[23:0] = root (unsigned Q8.16), m_tuser = negative_error
//
// One radicand is worked on at a time. Each Newton step runs one shared
// restoring divider over all VAL_W (47) quotient bits and then updates the guess;
// the largest inputs need the most steps. Negative inputs and a zero input
// skip the divider and go straight to the result.
// Reset (aresetn low, synchronous) empties the result register and idles the loop.
// A result waiting on m_tready does not block the next input transfer.

module newton_square_root (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nsr_pkg::IN_W-1:0]      s_tdata,   // [31:0] radicand
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nsr_pkg::ROOT_W-1:0]    m_tdata,   // [23:0] root
    output logic                          m_tuser    // [0] negative_error
);
    import nsr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [VAL_W-1:0]  v_reg, v_next;
    logic [VAL_W-1:0]  g_reg, g_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic              neg_reg, neg_next;
    logic              mvalid_reg, mvalid_next;
    logic [ROOT_W-1:0] mroot_reg, mroot_next;
    logic              mneg_reg, mneg_next;

    nsr_div_ctrl_t     div_ctrl;
    nsr_div_stat_t     div_stat;
    logic [VAL_W-1:0]  quot;

    logic [VAL_W-1:0]  v_in;
    logic [VAL_W:0]    sum;
    logic [VAL_W-1:0]  g_new;
    logic              out_free;

    assign v_in     = VAL_W'(s_tdata[IN_W-2:0]) << FRACTION_BITS;
    assign sum      = {1'b0, g_reg} + {1'b0, quot};
    assign g_new    = sum[VAL_W:1];
    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    nsr_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (v_reg),
        .divisor  (g_reg),
        .stat     (div_stat),
        .quotient (quot)
    );

    always_comb begin
        state_next     = state_reg;
        v_next         = v_reg;
        g_next         = g_reg;
        root_next      = root_reg;
        neg_next       = neg_reg;
        mvalid_next    = mvalid_reg;
        mroot_next     = mroot_reg;
        mneg_next      = mneg_reg;
        div_ctrl.start = 1'b0;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    v_next   = v_in;
                    g_next   = v_in >> 1;
                    neg_next = s_tdata[IN_W-1];
                    if (s_tdata[IN_W-1]) begin
                        root_next  = '0;
                        state_next = S_DONE;
                    end else if (v_in < VAL_W'(2)) begin
                        root_next  = v_in[ROOT_W-1:0];
                        state_next = S_DONE;
                    end else begin
                        state_next = S_UPD;
                    end
                end
            end
            // Launches the division of the value by the current guess, for the
            // first step and for every later one.
            S_UPD: begin
                div_ctrl.start = 1'b1;
                state_next     = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    // The guess stops shrinking exactly at the floor root.
                    if (g_new >= g_reg) begin
                        root_next  = g_reg[ROOT_W-1:0];
                        state_next = S_DONE;
                    end else begin
                        g_next     = g_new;
                        state_next = S_UPD;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mroot_next  = root_reg;
                    mneg_next   = neg_reg;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
        v_reg     <= v_next;
        g_reg     <= g_next;
        root_reg  <= root_next;
        neg_reg   <= neg_next;
        mroot_reg <= mroot_next;
        mneg_reg  <= mneg_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mroot_reg;
    assign m_tuser  = mneg_reg;

endmodule

[sim/nsr_root_checker.sv]
`timescale 1ns / 1ps

module nsr_root_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [nsr_pkg::IN_W-1:0]      s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [nsr_pkg::ROOT_W-1:0]    m_tdata,
    input  logic                          m_tuser,
    output int                            fail_count,
    output int                            roots_outstanding
);

    typedef struct packed {
        logic [nsr_pkg::IN_W-1:0]   radicand;
        logic [nsr_pkg::ROOT_W-1:0] root;
        logic                       negative_error;
    } root_result_t;

    root_result_t expected_roots [$];
    int failures    = 0;
    int outstanding = 0;

    assign fail_count        = failures;
    assign roots_outstanding = outstanding;

    // Integer Heron iteration from half the widened value. The guesses fall
    // toward the floor root and stop falling once they reach it.
    function automatic root_result_t predict_root(input logic [nsr_pkg::IN_W-1:0] radicand);
        root_result_t result;
        logic [63:0]  widened;
        logic [63:0]  guess;
        logic [63:0]  next_guess;
        result.radicand       = radicand;
        result.root           = '0;
        result.negative_error = radicand[nsr_pkg::IN_W-1];
        if (!result.negative_error) begin
            widened = 64'(radicand) << nsr_pkg::FRACTION_BITS;
            if (widened < 64'd2) begin
                guess = widened;
            end else begin
                guess      = widened / 64'd2;
                next_guess = (guess + widened / guess) / 64'd2;
                while (next_guess < guess) begin
                    guess      = next_guess;
                    next_guess = (guess + widened / guess) / 64'd2;
                end
            end
            result.root = guess[nsr_pkg::ROOT_W-1:0];
        end
        return result;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] radicand,
                                   input logic [31:0] got, input logic [31:0] want);
        $display("%0t ns: %s (radicand 0x%08h): got 0x%0h, expected 0x%0h",
                 $realtime, what, radicand, got, want);
        failures++;
    endtask

    always @(posedge aclk) begin
        root_result_t want;
        if (aresetn) begin
            // The result transfer is handled first; an input transfer in the
            // same cycle can never be the source of that result.
            if (m_tvalid && m_tready) begin
                if (expected_roots.size() == 0) begin
                    report_mismatch("result transfer with no radicand pending", '0,
                                    32'(m_tdata), '0);
                end else begin
                    want = expected_roots.pop_front();
                    if (m_tdata !== want.root)
                        report_mismatch("root mismatch", want.radicand,
                                        32'(m_tdata), 32'(want.root));
                    if (m_tuser !== want.negative_error)
                        report_mismatch("negative_error mismatch", want.radicand,
                                        32'(m_tuser), 32'(want.negative_error));
                end
            end
            if (s_tvalid && s_tready)
                expected_roots.push_back(predict_root(s_tdata));
        end
        outstanding <= expected_roots.size();
    end

endmodule

[sim/tb_newton_square_root.sv]
`timescale 1ns / 1ps

module tb_newton_square_root;

    localparam int CLOCK_LIMIT     = 4_000_000;
    localparam int TAIL_CYCLES     = 1300;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int MAX_GAP         = 40;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [nsr_pkg::IN_W-1:0]      s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [nsr_pkg::ROOT_W-1:0]    m_tdata;
    logic                          m_tuser;

    logic sender_idles    = 1'b0;
    logic receiver_stalls = 1'b0;
    int   idle_percent    = 73;
    int   stall_percent   = 73;
    int   cycle_count     = 0;
    int   fail_count;
    int   roots_outstanding;

    // Extremes, exact squares and their neighbors, values below one, and negatives.
    logic [31:0] directed_radicands [$] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
        32'h0000_FFFF, 32'h0001_0000, 32'h0004_0000, 32'h0002_0000,
        32'h7FFE_A810, 32'h7FFE_A80F, 32'h7FFE_A811, 32'h7FFF_0000,
        32'h7FFF_FFFF, 32'h5555_5555, 32'h8000_0000, 32'hFFFF_FFFF,
        32'hAAAA_AAAA, 32'hDEAD_BEEF
    };

    newton_square_root uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    nsr_root_checker root_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .fail_count        (fail_count),
        .roots_outstanding (roots_outstanding)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CLOCK_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= receiver_stalls ? ($urandom_range(99) >= stall_percent) : 1'b1;
    end

    function automatic logic [31:0] pick_radicand();
        int          kind;
        logic [31:0] base;
        kind = $urandom_range(99);
        if (kind < 25) begin
            return $urandom();
        end else if (kind < 40) begin
            return {1'b1, 31'($urandom())};
        end else if (kind < 60) begin
            return 32'($urandom_range(0, 65535));
        end else if (kind < 80) begin
            // A radicand of m*m widens to an exact square, so the root lands
            // on a boundary; one above and one below probe the floor.
            base = 32'($urandom_range(0, 46340));
            return base * base + 32'($urandom_range(0, 2)) - 32'd1;
        end else begin
            return {1'b0, 31'($urandom())} >> $urandom_range(0, 30);
        end
    endfunction

    task automatic push_radicand(input logic [31:0] value);
        int gap;
        gap = 0;
        if (sender_idles)
            while (gap < MAX_GAP && $urandom_range(99) < idle_percent) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the input channel quiet until every pending root has been transferred.
    task automatic wait_for_roots();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (roots_outstanding != 0);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_radicands[i])
            push_radicand(directed_radicands[i]);
        wait_for_roots();

        for (int phase = 0; phase < 4; phase++) begin
            // The sender settings are read only by this process.
            sender_idles    = (phase == 1) || (phase == 3);
            idle_percent    = (phase == 3) ? 34 : 73;
            receiver_stalls <= (phase == 2) || (phase == 3);
            stall_percent   <= (phase == 3) ? 34 : 73;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                push_radicand(pick_radicand());
            wait_for_roots();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && roots_outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
